>>> rtl/core/wcs_pkg.sv
`timescale 1ns / 1ps

package wcs_pkg;

   // request and response field widths
   localparam int OP_W    = 2;
   localparam int ADDR_W  = 14;
   localparam int DATA_W  = 8;
   localparam int QUOT_W  = 20;
   localparam int SIDX_W  = 23;
   localparam int WHEEL_W = 6;
   localparam int SEG_W   = 15;

   // walking index: a start index below 2**23 plus one wheel step
   localparam int IDX_W = 24;

   localparam logic [SEG_W-1:0] SEG_RESET = 15'd16384;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_CROSS = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // bit cleared at each wheel position
   localparam logic [2:0] WHEEL_BIT [64] = '{
      3'd0, 3'd4, 3'd3, 3'd7, 3'd6, 3'd2, 3'd1, 3'd5,
      3'd1, 3'd3, 3'd7, 3'd5, 3'd0, 3'd6, 3'd2, 3'd4,
      3'd2, 3'd7, 3'd5, 3'd4, 3'd1, 3'd0, 3'd6, 3'd3,
      3'd3, 3'd6, 3'd0, 3'd1, 3'd4, 3'd5, 3'd7, 3'd2,
      3'd4, 3'd2, 3'd6, 3'd0, 3'd5, 3'd7, 3'd3, 3'd1,
      3'd5, 3'd1, 3'd2, 3'd6, 3'd7, 3'd3, 3'd4, 3'd0,
      3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd7,
      3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6
   };

   // quotient multiplier for each step within a group
   localparam logic [2:0] WHEEL_FACTOR [8] = '{
      3'd6, 3'd4, 3'd2, 3'd4, 3'd2, 3'd4, 3'd6, 3'd2
   };

   // constant addend at each wheel position
   localparam logic [2:0] WHEEL_ADDEND [64] = '{
      3'd1, 3'd1, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd1, 3'd1, 3'd2, 3'd0, 3'd2, 3'd2, 3'd1,
      3'd2, 3'd2, 3'd1, 3'd2, 3'd1, 3'd1, 3'd3, 3'd1,
      3'd3, 3'd3, 3'd1, 3'd2, 3'd1, 3'd2, 3'd4, 3'd1,
      3'd4, 3'd2, 3'd2, 3'd2, 3'd1, 3'd3, 3'd4, 3'd1,
      3'd5, 3'd3, 3'd1, 3'd3, 3'd2, 3'd3, 3'd5, 3'd1,
      3'd6, 3'd4, 3'd2, 3'd4, 3'd2, 3'd4, 3'd5, 3'd2,
      3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
   };

   typedef struct packed {
      logic take_req;    // latch request, do load write or read access
      logic walk_read;   // fetch sieve byte at walking index
      logic walk_write;  // write back cleared byte, advance index and wheel
      logic rsp_load;    // capture response payload
   } cmd_type;

   typedef struct packed {
      logic in_range;    // walking index below segment end
   } stat_type;

endpackage

>>> rtl/core/wcs_chan_if.sv
`timescale 1ns / 1ps

interface wcs_req_if import wcs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      operation;
   logic [ADDR_W-1:0]    byte_address;
   logic [DATA_W-1:0]    byte_data;
   logic [QUOT_W-1:0]    prime_quotient;
   logic [SIDX_W-1:0]    start_index;
   logic [WHEEL_W-1:0]   start_wheel;

   modport source (output valid, operation, byte_address, byte_data, prime_quotient,
                   start_index, start_wheel, input ready);
   modport sink (input valid, operation, byte_address, byte_data, prime_quotient,
                 start_index, start_wheel, output ready);
endinterface

interface wcs_rsp_if import wcs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SIDX_W-1:0]    next_index;
   logic [WHEEL_W-1:0]   next_wheel;
   logic [DATA_W-1:0]    read_byte;

   modport source (output valid, next_index, next_wheel, read_byte, input ready);
   modport sink (input valid, next_index, next_wheel, read_byte, output ready);
endinterface

>>> rtl/core/wcs_ctrl.sv
`timescale 1ns / 1ps

module wcs_ctrl import wcs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [OP_W-1:0] req_operation,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output cmd_type         cmd,
   input  stat_type        stat
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_WRITE = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in = (req_operation == OP_CROSS) ? S_CHECK : S_DONE;
            end
         end
         S_CHECK: begin
            if (stat.in_range) begin
               cmd.walk_read = 1'b1;
               state_in = S_WRITE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WRITE: begin
            cmd.walk_write = 1'b1;
            state_in = S_CHECK;
         end
         S_DONE: begin
            // hold the result until the response register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/wcs_datapath.sv
`timescale 1ns / 1ps

module wcs_datapath import wcs_pkg::*; #(
   parameter int SIEVE_DEPTH = 16384
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [ADDR_W-1:0]  req_byte_address,
   input  logic [DATA_W-1:0]  req_byte_data,
   input  logic [QUOT_W-1:0]  req_prime_quotient,
   input  logic [SIDX_W-1:0]  req_start_index,
   input  logic [WHEEL_W-1:0] req_start_wheel,
   input  logic               csr_write_enable,
   input  logic [SEG_W-1:0]   csr_write_data,
   input  cmd_type            cmd,
   output stat_type           stat,
   output logic [SIDX_W-1:0]  rsp_next_index,
   output logic [WHEEL_W-1:0] rsp_next_wheel,
   output logic [DATA_W-1:0]  rsp_read_byte
);

   localparam int AW = $clog2(SIEVE_DEPTH);
   localparam logic [IDX_W-1:0] LIMIT_RESET =
      (32'(SEG_RESET) > SIEVE_DEPTH) ? IDX_W'(SIEVE_DEPTH) : IDX_W'(SEG_RESET);

   logic [DATA_W-1:0] sieve_mem [SIEVE_DEPTH];

   logic [IDX_W-1:0]   limit_ff, limit_in;
   logic [OP_W-1:0]    op_ff;
   logic               addr_ok_ff;
   logic [QUOT_W-1:0]  quot_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [WHEEL_W-1:0] wheel_ff, wheel_in;
   logic [DATA_W-1:0]  rd_data_ff;
   logic [SIDX_W-1:0]  next_index_ff;
   logic [WHEEL_W-1:0] next_wheel_ff;
   logic [DATA_W-1:0]  read_byte_ff;

   logic               addr_ok;
   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [DATA_W-1:0]  wr_data;
   logic [SIDX_W-1:0]  step_prod;
   logic [DATA_W-1:0]  clear_mask;

   // segment end never runs past the store
   assign limit_in = (32'(csr_write_data) > SIEVE_DEPTH) ? IDX_W'(SIEVE_DEPTH)
                                                         : IDX_W'(csr_write_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= limit_in;
      end
   end

   assign addr_ok  = 32'(req_byte_address) < SIEVE_DEPTH;
   assign stat.in_range = idx_ff < limit_ff;

   assign step_prod  = SIDX_W'(quot_ff) * SIDX_W'(WHEEL_FACTOR[wheel_ff[2:0]]);
   assign idx_in     = idx_ff + IDX_W'(step_prod) + IDX_W'(WHEEL_ADDEND[wheel_ff]);
   assign wheel_in   = {wheel_ff[5:3], wheel_ff[2:0] + 3'd1};
   assign clear_mask = ~(DATA_W'(1) << WHEEL_BIT[wheel_ff]);

   // single write port: load request or walk write-back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data_ff & clear_mask;
      rd_en   = cmd.walk_read;
      rd_addr = idx_ff[AW-1:0];
      if (cmd.take_req) begin
         wr_en   = (req_operation == OP_LOAD) && addr_ok;
         wr_addr = AW'(req_byte_address);
         wr_data = req_byte_data;
         rd_en   = (req_operation == OP_READ) && addr_ok;
         rd_addr = AW'(req_byte_address);
      end else if (cmd.walk_write) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sieve_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= sieve_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         op_ff      <= req_operation;
         addr_ok_ff <= addr_ok;
         quot_ff    <= req_prime_quotient;
         idx_ff     <= IDX_W'(req_start_index);
         wheel_ff   <= req_start_wheel;
      end else if (cmd.walk_write) begin
         idx_ff   <= idx_in;
         wheel_ff <= wheel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         next_index_ff <= '0;
         next_wheel_ff <= '0;
         read_byte_ff  <= '0;
         case (op_ff)
            OP_CROSS: begin
               next_index_ff <= SIDX_W'(idx_ff - limit_ff);
               next_wheel_ff <= wheel_ff;
            end
            OP_READ: begin
               if (addr_ok_ff) begin
                  read_byte_ff <= rd_data_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_next_index = next_index_ff;
   assign rsp_next_wheel = next_wheel_ff;
   assign rsp_read_byte  = read_byte_ff;

endmodule

>>> rtl/core/wheel30_sieve_cross_off.sv
`timescale 1ns / 1ps
// Load and read: taken in idle, then the done state loads the response once the output
// register is free. Cross-off: check and write states alternate over the sieve bytes
// walked, each a read then a write of the memory. No request is taken until done ends.
// A finished response waits in the output register while the next request is taken.
// Reset: control idles, segment length returns to 16384 (capped at SIEVE_DEPTH);
// the sieve memory is not cleared.

module wheel30_sieve_cross_off import wcs_pkg::*; #(
   parameter int SIEVE_DEPTH = 16384
) (
   input  logic             clock,
   input  logic             reset,
   wcs_req_if.sink          req_ch,
   wcs_rsp_if.source        rsp_ch,
   input  logic             csr_write_enable,
   input  logic [SEG_W-1:0] csr_write_data
);

   cmd_type  cmd;
   stat_type stat;
   logic     ctl_req_ready;
   logic     ctl_rsp_valid;

   wcs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (ctl_req_ready),
      .req_operation (req_ch.operation),
      .rsp_valid     (ctl_rsp_valid),
      .rsp_ready     (rsp_ch.ready),
      .cmd           (cmd),
      .stat          (stat)
   );

   wcs_datapath #(
      .SIEVE_DEPTH (SIEVE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_operation      (req_ch.operation),
      .req_byte_address   (req_ch.byte_address),
      .req_byte_data      (req_ch.byte_data),
      .req_prime_quotient (req_ch.prime_quotient),
      .req_start_index    (req_ch.start_index),
      .req_start_wheel    (req_ch.start_wheel),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_next_index     (rsp_ch.next_index),
      .rsp_next_wheel     (rsp_ch.next_wheel),
      .rsp_read_byte      (rsp_ch.read_byte)
   );

   assign req_ch.ready = ctl_req_ready;
   assign rsp_ch.valid = ctl_rsp_valid;

   // a taken request always leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request ready stayed high after a request was taken");

   // write-back only for a byte fetched inside the segment
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_write |-> ($past(stat.in_range) && $past(cmd.walk_read)))
      else $error("walk write-back without an in-range fetch");

   // read data and cross-off results never share a response
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.read_byte == '0 ||
                        (rsp_ch.next_index == '0 && rsp_ch.next_wheel == '0)))
      else $error("response carries both read data and cross-off result");

   // no new request is taken while a walk is in flight
   a_no_take_in_walk: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_read || cmd.walk_write) |-> !cmd.take_req)
      else $error("request taken during a cross-off walk");

endmodule

>>> test/wheel30_sieve_cross_off_tb.sv
`timescale 1ns / 1ps

module wheel30_sieve_cross_off_tb;
   import wcs_pkg::*;

   localparam int STORE_DEPTH = 16384;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int WALK_CAP = 600;
   localparam int RANDOM_ITEMS = 470;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [ADDR_W-1:0]  byte_address;
      logic [DATA_W-1:0]  byte_data;
      logic [QUOT_W-1:0]  prime_quotient;
      logic [SIDX_W-1:0]  start_index;
      logic [WHEEL_W-1:0] start_wheel;
   } sieve_req_type;

   typedef struct packed {
      logic [SIDX_W-1:0]  next_index;
      logic [WHEEL_W-1:0] next_wheel;
      logic [DATA_W-1:0]  read_byte;
   } sieve_rsp_type;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [SEG_W-1:0] csr_write_data;

   wcs_req_if req_ch ();
   wcs_rsp_if rsp_ch ();

   wheel30_sieve_cross_off u_top (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // predicted contents of the sieve memory and the segment register
   logic [DATA_W-1:0] sieve_image [STORE_DEPTH];
   bit                byte_written [STORE_DEPTH];
   int                written_addrs [$];
   int                path_unwritten [$];
   logic [SEG_W-1:0]  segment_setting = SEG_RESET;

   sieve_rsp_type responses_due [$];
   int            fail_count = 0;
   int            requests_sent = 0;
   bit            req_raised = 1'b0;
   bit            steady_flow = 1'b0;
   int            rsp_hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned segment_end();
      return (segment_setting > STORE_DEPTH) ? STORE_DEPTH : int'(segment_setting);
   endfunction

   function automatic void wheel_advance(input logic [QUOT_W-1:0] quotient,
                                         inout int unsigned pos,
                                         inout logic [WHEEL_W-1:0] wheel);
      pos = pos + quotient * WHEEL_FACTOR[wheel[2:0]] + WHEEL_ADDEND[wheel];
      wheel = {wheel[5:3], wheel[2:0] + 3'd1};
   endfunction

   // Count the bytes a cross-off walks and collect those never loaded.
   function automatic int plan_walk(input logic [QUOT_W-1:0] quotient,
                                    input logic [SIDX_W-1:0] index,
                                    input logic [WHEEL_W-1:0] wheel);
      int unsigned        pos;
      int unsigned        lim;
      logic [WHEEL_W-1:0] wh;
      int                 steps;
      pos = index;
      wh = wheel;
      lim = segment_end();
      steps = 0;
      path_unwritten.delete();
      while (pos < lim && steps <= 4 * WALK_CAP) begin
         if (!byte_written[pos])
            path_unwritten.push_back(pos);
         wheel_advance(quotient, pos, wh);
         steps++;
      end
      return steps;
   endfunction

   function automatic logic [QUOT_W-1:0] quotient_within_cap(input logic [QUOT_W-1:0] q,
                                                              input logic [SIDX_W-1:0] index,
                                                              input logic [WHEEL_W-1:0] wheel);
      // grow the quotient until the walk stays short
      while (plan_walk(q, index, wheel) > WALK_CAP)
         q = {q[QUOT_W-2:0], 1'b1};
      return q;
   endfunction

   function automatic sieve_rsp_type sieve_response_for(input sieve_req_type r);
      sieve_rsp_type      rsp;
      int unsigned        pos;
      int unsigned        lim;
      logic [WHEEL_W-1:0] wh;
      rsp = '0;
      case (r.operation)
         OP_LOAD: begin
            sieve_image[r.byte_address] = r.byte_data;
            if (!byte_written[r.byte_address]) begin
               byte_written[r.byte_address] = 1'b1;
               written_addrs.push_back(r.byte_address);
            end
         end
         OP_READ: rsp.read_byte = sieve_image[r.byte_address];
         OP_CROSS: begin
            lim = segment_end();
            pos = r.start_index;
            wh = r.start_wheel;
            while (pos < lim) begin
               sieve_image[pos] = sieve_image[pos] & ~(8'd1 << WHEEL_BIT[wh]);
               wheel_advance(r.prime_quotient, pos, wh);
            end
            rsp.next_index = SIDX_W'(pos - lim);
            rsp.next_wheel = wh;
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic sieve_req_type scrambled_request(input logic [OP_W-1:0] op);
      sieve_req_type r;
      r.operation = op;
      r.byte_address = ADDR_W'($urandom);
      r.byte_data = DATA_W'($urandom);
      r.prime_quotient = QUOT_W'($urandom);
      r.start_index = SIDX_W'($urandom);
      r.start_wheel = WHEEL_W'($urandom);
      return r;
   endfunction

   task automatic report_error(input string what, input sieve_rsp_type want,
                               input sieve_rsp_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("ERROR %s at %0t", what, $time);
         $display("   expected idx %0d wheel %0d byte %02h / got idx %0d wheel %0d byte %02h",
                  want.next_index, want.next_wheel, want.read_byte,
                  got.next_index, got.next_wheel, got.read_byte);
      end
   endtask

   task automatic send_request(input sieve_req_type r, output sieve_rsp_type due);
      req_ch.valid <= 1'b1;
      req_ch.operation <= r.operation;
      req_ch.byte_address <= r.byte_address;
      req_ch.byte_data <= r.byte_data;
      req_ch.prime_quotient <= r.prime_quotient;
      req_ch.start_index <= r.start_index;
      req_ch.start_wheel <= r.start_wheel;
      req_raised = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      due = sieve_response_for(r);
      responses_due.push_back(due);
      requests_sent++;
      if (!steady_flow && $urandom_range(99) < 17) begin
         req_ch.valid <= 1'b0;
         req_raised = 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 17);
      end
   endtask

   task automatic wait_results_done();
      if (req_raised) begin
         req_ch.valid <= 1'b0;
         req_raised = 1'b0;
      end
      do @(posedge clock); while (responses_due.size() != 0);
   endtask

   task automatic write_segment(input logic [SEG_W-1:0] value);
      wait_results_done();
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      segment_setting = value;
   endtask

   task automatic load_byte(input int addr, input logic [DATA_W-1:0] data);
      sieve_req_type r;
      sieve_rsp_type due;
      r = scrambled_request(OP_LOAD);
      r.byte_address = ADDR_W'(addr);
      r.byte_data = data;
      send_request(r, due);
   endtask

   task automatic read_byte_back(input int addr);
      sieve_req_type r;
      sieve_rsp_type due;
      r = scrambled_request(OP_READ);
      r.byte_address = ADDR_W'(addr);
      send_request(r, due);
   endtask

   task automatic spare_op();
      sieve_rsp_type due;
      send_request(scrambled_request(OP_SPARE), due);
   endtask

   // Load every byte the walk will touch that holds nothing yet, then cross off.
   task automatic cross_off(input logic [QUOT_W-1:0] quotient, input logic [SIDX_W-1:0] index,
                            input logic [WHEEL_W-1:0] wheel, output sieve_rsp_type due);
      sieve_req_type r;
      void'(plan_walk(quotient, index, wheel));
      foreach (path_unwritten[k])
         if (!byte_written[path_unwritten[k]])
            load_byte(path_unwritten[k], DATA_W'($urandom));
      r = scrambled_request(OP_CROSS);
      r.prime_quotient = quotient;
      r.start_index = index;
      r.start_wheel = wheel;
      send_request(r, due);
   endtask

   task automatic random_noise();
      sieve_rsp_type      due;
      logic [QUOT_W-1:0]  q;
      logic [SIDX_W-1:0]  start;
      logic [WHEEL_W-1:0] wh;
      case ($urandom_range(3))
         0: read_byte_back(written_addrs[$urandom_range(written_addrs.size() - 1)]);
         1: spare_op();
         2: load_byte($urandom_range(STORE_DEPTH - 1), DATA_W'($urandom));
         default: begin
            q = QUOT_W'($urandom);
            start = SIDX_W'($urandom);
            wh = WHEEL_W'($urandom);
            q = quotient_within_cap(q, start, wh);
            cross_off(q, start, wh, due);
         end
      endcase
   endtask

   task automatic test_load_read_extremes();
      load_byte(0, 8'hFF);
      load_byte(STORE_DEPTH - 1, 8'h00);
      load_byte(1, 8'h5A);
      load_byte(1, 8'hA5);
      read_byte_back(0);
      read_byte_back(STORE_DEPTH - 1);
      read_byte_back(1);
      spare_op();
   endtask

   task automatic test_reset_segment_cross();
      sieve_rsp_type due;
      cross_off(20'hFFFFF, 23'd0, 6'd0, due);
      cross_off(20'hFFFFF, 23'd16383, 6'd63, due);
      // start right at the segment end and at the top of the index range
      cross_off(20'd0, 23'd16384, 6'd7, due);
      cross_off(20'd0, 23'h7FFFFF, 6'd63, due);
      cross_off(20'd2000, 23'd5, 6'd9, due);
      read_byte_back(0);
      read_byte_back(STORE_DEPTH - 1);
   endtask

   task automatic test_segment_settings();
      sieve_rsp_type due;
      // empty segment: nothing cleared, index passes through
      write_segment(15'd0);
      cross_off(20'd0, 23'd0, 6'd56, due);
      // one-byte segment with zero addends along the walk
      write_segment(15'd1);
      cross_off(20'd0, 23'd0, 6'd57, due);
      cross_off(20'd0, 23'd0, 6'd2, due);
      read_byte_back(0);
      // segment longer than the memory
      write_segment(15'h7FFF);
      cross_off(20'd1, 23'd16383, 6'd40, due);
      read_byte_back(STORE_DEPTH - 1);
   endtask

   task automatic test_full_output_stall();
      sieve_rsp_type due;
      write_segment(15'd16);
      // hold the response side while requests keep coming
      rsp_hold_cycles = 300;
      for (int a = 0; a < 16; a++)
         load_byte(a, 8'hFF);
      cross_off(20'd0, 23'd1, 6'd8, due);
      cross_off(20'd0, 23'd3, 6'd16, due);
      cross_off(20'd1, 23'd2, 6'd48, due);
      for (int a = 0; a < 16; a++)
         read_byte_back(a);
      wait_results_done();
   endtask

   task automatic test_random_segments();
      int                 quota_end;
      int                 shape;
      int                 seg;
      int                 lim;
      int                 n_primes;
      int                 round;
      logic [QUOT_W-1:0]  quot [8];
      logic [SIDX_W-1:0]  idx [8];
      logic [WHEEL_W-1:0] whl [8];
      sieve_rsp_type      due;
      quota_end = requests_sent + RANDOM_ITEMS;
      round = 0;
      while (requests_sent < quota_end) begin
         shape = $urandom_range(9);
         if (shape == 0)
            seg = ($urandom_range(1) == 0) ? 16384 : $urandom_range(16385, 32767);
         else if (shape == 1)
            seg = $urandom_range(200, 600);
         else
            seg = $urandom_range(1, 32);
         write_segment(SEG_W'(seg));
         steady_flow = (round == 2);
         lim = segment_end();
         n_primes = $urandom_range(1, 8);
         for (int p = 0; p < n_primes; p++) begin
            if (shape == 0)
               quot[p] = QUOT_W'($urandom_range(1000, 1048575));
            else begin
               case ($urandom_range(9))
                  0, 1, 2, 3, 4: quot[p] = QUOT_W'($urandom_range(7));
                  5, 6, 7: quot[p] = QUOT_W'($urandom_range(8, 255));
                  default: quot[p] = QUOT_W'($urandom);
               endcase
            end
            whl[p] = WHEEL_W'($urandom_range(63));
            idx[p] = SIDX_W'($urandom_range(lim - 1));
         end
         // walk consecutive segments, carrying each prime's index and wheel forward
         for (int s = 0; s < 3; s++) begin
            if (shape > 1)
               for (int a = 0; a < lim; a++)
                  load_byte(a, ($urandom_range(1) == 1) ? 8'hFF : DATA_W'($urandom));
            for (int p = 0; p < n_primes; p++) begin
               if ($urandom_range(99) < 15)
                  random_noise();
               quot[p] = quotient_within_cap(quot[p], idx[p], whl[p]);
               cross_off(quot[p], idx[p], whl[p], due);
               idx[p] = due.next_index;
               whl[p] = due.next_wheel;
            end
            if (shape > 1)
               for (int a = 0; a < lim; a++)
                  read_byte_back(a);
            else
               repeat (6) read_byte_back(written_addrs[$urandom_range(written_addrs.size() - 1)]);
         end
         round++;
      end
      steady_flow = 1'b0;
   endtask

   // response side: random back-pressure plus a counted hold
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 17);
         end
      end
   end

   initial begin
      sieve_rsp_type got;
      sieve_rsp_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.next_index = rsp_ch.next_index;
            got.next_wheel = rsp_ch.next_wheel;
            got.read_byte = rsp_ch.read_byte;
            if (responses_due.size() == 0) begin
               report_error("response with no request pending", '0, got);
            end else begin
               want = responses_due.pop_front();
               if (got.next_index !== want.next_index || got.next_wheel !== want.next_wheel
                   || got.read_byte !== want.read_byte)
                  report_error("response mismatch", want, got);
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("wheel30_sieve_cross_off regression: fail");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.operation <= '0;
      req_ch.byte_address <= '0;
      req_ch.byte_data <= '0;
      req_ch.prime_quotient <= '0;
      req_ch.start_index <= '0;
      req_ch.start_wheel <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_load_read_extremes();
      test_reset_segment_cross();
      test_segment_settings();
      test_full_output_stall();
      test_random_segments();

      wait_results_done();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && responses_due.size() == 0)
         $display("wheel30_sieve_cross_off regression: pass");
      else
         $display("wheel30_sieve_cross_off regression: fail");
      $finish;
   end

endmodule
